### hdl/nrbp_pkg.sv
// Package for the nearest ray-box pick block: widths, register indexes, state codes.
// No dependencies; used by every module in hdl/.
`timescale 1ns / 1ps
package nrbp_pkg;
	localparam int FracBits = 16;
	localparam int CoordW = 32;
	localparam int DistW = 31;
	localparam int IdxW = 10;
	// Dividend is a 33-bit difference shifted left by the fraction bits.
	localparam int DivW = 33 + FracBits;

	localparam logic [2:0] RegOrgX = 3'd0;
	localparam logic [2:0] RegOrgY = 3'd1;
	localparam logic [2:0] RegOrgZ = 3'd2;
	localparam logic [2:0] RegDirX = 3'd3;
	localparam logic [2:0] RegDirY = 3'd4;
	localparam logic [2:0] RegDirZ = 3'd5;
	localparam logic [2:0] RegMaxD = 3'd6;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_AXIS,
		ST_DIV,
		ST_NEXT,
		ST_DONE,
		ST_OUT
	} state_t;
endpackage

### hdl/nrbp_div.sv
// Shared signed divider, restoring, one quotient bit per cycle, truncating toward zero.
// Depends on nrbp_pkg.
`timescale 1ns / 1ps
module nrbp_div
	import nrbp_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [DivW-1:0]  dividend,
	input  logic signed [CoordW-1:0] divisor,
	output logic                    done,
	output logic signed [DivW:0]    quotient
);
	localparam int CW = $clog2(DivW + 1);
	logic [DivW-1:0] rem_q, quo_q, num_q;
	logic [CoordW-1:0] den_q;
	logic neg_q;
	logic [CW-1:0] cnt_q;
	logic busy_q, done_q;
	logic [DivW:0] trial;
	logic [DivW:0] shifted;

	// One restoring step on the partial remainder.
	always_comb begin
		shifted = {rem_q, num_q[DivW-1]};
		trial = shifted - {{(DivW + 1 - CoordW){1'b0}}, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(DivW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Magnitudes are loaded at start, the sign is restored at the end.
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend[DivW-1] ? DivW'(-dividend) : DivW'(dividend);
			den_q <= divisor[CoordW-1] ? CoordW'(-divisor) : CoordW'(divisor);
			neg_q <= dividend[DivW-1] ^ divisor[CoordW-1];
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[DivW-2:0], 1'b0};
			if (!trial[DivW]) begin
				rem_q <= trial[DivW-1:0];
				quo_q <= {quo_q[DivW-2:0], 1'b1};
			end else begin
				rem_q <= shifted[DivW-1:0];
				quo_q <= {quo_q[DivW-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quotient = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
endmodule

### hdl/nearest_ray_box_pick_top.sv
// Top level of the nearest ray-box pick block: config registers, sequencer, best tracking.
// Depends on nrbp_pkg and nrbp_div.
`timescale 1ns / 1ps
// Usage: write the ray origin, direction and maximum distance through the
// config port (cfg_we, cfg_index, cfg_data) while the block is idle. Then
// stream boxes on the s_axis channel; tuser carries selectable and tlast marks
// the last box of a scene. For the last box one result transfer appears on
// m_axis: tdata holds hit_found, hit_index and hit_distance.
// A box passes through an axis check for each axis in turn; an axis with a
// nonzero direction adds two 49-step divisions through one shared bit-serial
// divider, the lower bound and then the upper, and every axis ends with the
// axis advance. The last box of a scene then loads the result once the output
// register is free. An unselectable box skips the axes, and a box that misses
// stops after the failing axis.
// s_axis_tready is high only while the sequencer is idle. If the receiver
// stalls, the result is held in its output register and boxes keep flowing;
// only the next scene result waits until that transfer completes.
// Reset returns the registers to origin 0, direction (1,0,0), maximum 8.0,
// and clears the box count and the best hit.
module nearest_ray_box_pick_top
	import nrbp_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// box_min_x, box_max_x, box_min_y, box_max_y, box_min_z, box_max_z
	input  logic [191:0] s_axis_tdata,
	// selectable
	input  logic         s_axis_tuser,
	input  logic         s_axis_tlast,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// hit_found, hit_index[9:0], hit_distance[30:0], zero padding
	output logic [47:0]  m_axis_tdata
);
	localparam logic signed [DivW:0] TNeg = {2'b11, {(DivW - 1){1'b0}}};
	localparam logic signed [DivW:0] TPos = {2'b00, {(DivW - 1){1'b1}}};

	logic signed [CoordW-1:0] org_q [3];
	logic signed [CoordW-1:0] dir_q [3];
	logic [DistW-1:0] maxd_q;
	logic signed [CoordW-1:0] bnd_q [6];
	logic sel_q, last_q;
	state_t state_q, state_d;
	logic [1:0] axis_q;
	logic half_q;
	logic signed [DivW:0] t1_q, tmin_q, tmax_q;
	logic miss_q;
	logic [IdxW-1:0] cnt_q, bpos_q;
	logic [DistW:0] bdist_q;
	logic bval_q;
	logic ovalid_q;
	logic [47:0] odata_q;
	logic div_start, div_done;
	logic signed [DivW:0] quo;
	logic signed [CoordW:0] lo_diff, hi_diff, cur_diff;
	logic signed [DivW-1:0] dividend;
	logic signed [DivW:0] lo_t, hi_t, tsel;
	logic take;

	// Config register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			org_q[0] <= '0; org_q[1] <= '0; org_q[2] <= '0;
			dir_q[0] <= 32'sd65536; dir_q[1] <= '0; dir_q[2] <= '0;
			maxd_q <= 31'd524288;
		end else if (cfg_we) begin
			case (cfg_index)
				RegOrgX: org_q[0] <= cfg_data;
				RegOrgY: org_q[1] <= cfg_data;
				RegOrgZ: org_q[2] <= cfg_data;
				RegDirX: dir_q[0] <= cfg_data;
				RegDirY: dir_q[1] <= cfg_data;
				RegDirZ: dir_q[2] <= cfg_data;
				RegMaxD: maxd_q <= cfg_data[DistW-1:0];
				default: ;
			endcase
		end
	end

	// Operand selection for the current axis. The lower bound is divided when
	// the axis starts, the upper bound when the first quotient is done.
	always_comb begin
		lo_diff = {bnd_q[{axis_q, 1'b0}][CoordW-1], bnd_q[{axis_q, 1'b0}]}
			- {org_q[axis_q][CoordW-1], org_q[axis_q]};
		hi_diff = {bnd_q[{axis_q, 1'b1}][CoordW-1], bnd_q[{axis_q, 1'b1}]}
			- {org_q[axis_q][CoordW-1], org_q[axis_q]};
		cur_diff = (state_q == ST_DIV) ? hi_diff : lo_diff;
		dividend = {cur_diff, {FracBits{1'b0}}};
		lo_t = (t1_q < quo) ? t1_q : quo;
		hi_t = (t1_q < quo) ? quo : t1_q;
		tsel = (tmin_q >= 0) ? tmin_q : tmax_q;
	end

	nrbp_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(dividend), .divisor(dir_q[axis_q]),
		.done(div_done), .quotient(quo)
	);

	assign take = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);

	// Next-state logic of the sequencer.
	always_comb begin
		state_d = state_q;
		div_start = 1'b0;
		case (state_q)
			ST_IDLE: if (take) state_d = ST_AXIS;
			ST_AXIS: begin
				if (miss_q || axis_q == 2'd3) state_d = ST_DONE;
				else if (dir_q[axis_q] == 0) state_d = ST_NEXT;
				else begin
					div_start = 1'b1;
					state_d = ST_DIV;
				end
			end
			ST_DIV: if (div_done) begin
				if (!half_q) begin
					div_start = 1'b1;
				end else state_d = ST_NEXT;
			end
			ST_NEXT: state_d = ST_AXIS;
			ST_DONE: state_d = last_q ? ST_OUT : ST_IDLE;
			// The result loads once the output register is free.
			ST_OUT: if (!ovalid_q || m_axis_tready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// Input capture.
	always_ff @(posedge clk) begin
		if (take) begin
			for (int i = 0; i < 6; i++) bnd_q[i] <= s_axis_tdata[32*i +: 32];
			sel_q <= s_axis_tuser;
			last_q <= s_axis_tlast;
		end
	end

	// Slab interval tracking and best-hit state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_q <= '0; half_q <= 1'b0; miss_q <= 1'b0;
			cnt_q <= '0; bpos_q <= '0; bdist_q <= {1'b0, {DistW{1'b1}}};
			bval_q <= 1'b0; ovalid_q <= 1'b0;
			tmin_q <= TNeg; tmax_q <= TPos; t1_q <= '0;
			odata_q <= '0;
		end else begin
			if (m_axis_tvalid && m_axis_tready && state_q != ST_OUT) ovalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (take) begin
					axis_q <= '0; half_q <= 1'b0;
					miss_q <= !s_axis_tuser;
					tmin_q <= TNeg; tmax_q <= TPos;
				end
				ST_AXIS: if (!miss_q && axis_q != 2'd3 && dir_q[axis_q] == 0) begin
					if (lo_diff > 0 || hi_diff < 0) miss_q <= 1'b1;
				end
				ST_DIV: if (div_done) begin
					if (!half_q) begin
						t1_q <= quo;
						half_q <= 1'b1;
					end else begin
						half_q <= 1'b0;
						if (lo_t > tmin_q) tmin_q <= lo_t;
						if (hi_t < tmax_q) tmax_q <= hi_t;
					end
				end
				ST_NEXT: begin
					if (tmin_q > tmax_q) miss_q <= 1'b1;
					axis_q <= axis_q + 2'd1;
				end
				ST_DONE: begin
					// A strictly nearer hit wins; a saturated distance never does.
					if (!miss_q && sel_q && tsel >= 0) begin
						if (tsel < $signed({{(DivW - DistW){1'b0}}, bdist_q})) begin
							bdist_q <= tsel[DistW:0];
							bpos_q <= cnt_q;
							bval_q <= 1'b1;
						end
					end
					if (!last_q) cnt_q <= cnt_q + 1'b1;
				end
				ST_OUT: if (!ovalid_q || m_axis_tready) begin
					ovalid_q <= 1'b1;
					if (bval_q && bdist_q <= {1'b0, maxd_q})
						odata_q <= {6'd0, bdist_q[DistW-1:0], bpos_q, 1'b1};
					else odata_q <= '0;
					cnt_q <= '0; bpos_q <= '0; bval_q <= 1'b0;
					bdist_q <= {1'b0, {DistW{1'b1}}};
				end
				default: ;
			endcase
		end
	end

	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata = odata_q;
endmodule

### tb/nearest_ray_box_pick_top_tb.sv
// Testbench for nearest_ray_box_pick_top: streams boxes against configured rays and
// checks each nearest-hit transfer against an in-bench slab-test predictor.
// Depends on nrbp_pkg and the RTL under hdl/.
`timescale 1ns / 1ps
module nearest_ray_box_pick_top_tb;
	import nrbp_pkg::*;

	localparam longint CycleLimit = 4000000;
	localparam longint DistSat = 64'h7FFF_FFFF;
	localparam longint OpenEnd = 64'sd1 <<< 62;
	localparam logic [2:0] RegNone = 3'd7;

	typedef struct {
		logic [31:0] bmin [3];
		logic [31:0] bmax [3];
		logic        sel;
		logic        last;
	} box_t;

	typedef struct {
		logic        found;
		logic [9:0]  index;
		logic [30:0] distance;
	} pick_t;

	logic         clk;
	logic         arst_n;
	logic         cfg_we;
	logic [2:0]   cfg_index;
	logic [31:0]  cfg_data;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [191:0] s_axis_tdata;
	logic         s_axis_tuser;
	logic         s_axis_tlast;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [47:0]  m_axis_tdata;

	// Mirror of the ray registers and the running scene state.
	logic [31:0] ray_org [3];
	logic [31:0] ray_dir [3];
	logic [30:0] max_dist;
	logic [9:0]  box_count;
	longint      best_dist;
	logic [9:0]  best_pos;
	logic        best_ok;

	pick_t  pending_picks [$];
	int     mismatches;
	longint cycles = 0;
	int     send_idle_pct;
	int     recv_stall_pct;

	nearest_ray_box_pick_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Run watchdog.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Receiver readiness, redrawn every cycle.
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Result checker: valid and ready are stable at the falling edge before the transfer.
	always @(negedge clk) begin
		pick_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_picks.size() == 0) begin
				$error("unexpected result transfer: tdata %h", m_axis_tdata);
				mismatches++;
			end else begin
				want = pending_picks.pop_front();
				if (m_axis_tdata[0] !== want.found) begin
					$error("hit_found: expected %0d, actual %0d", want.found, m_axis_tdata[0]);
					mismatches++;
				end
				if (m_axis_tdata[10:1] !== want.index) begin
					$error("hit_index: expected %0d, actual %0d", want.index,
						m_axis_tdata[10:1]);
					mismatches++;
				end
				if (m_axis_tdata[41:11] !== want.distance) begin
					$error("hit_distance: expected %h, actual %h", want.distance,
						m_axis_tdata[41:11]);
					mismatches++;
				end
			end
		end
	end

	// Slab test of one box; returns -1 on a miss, otherwise the saturated distance.
	function automatic longint slab_distance(box_t b);
		longint tnear, tfar, lo, hi, t1, t2, d, t;
		tnear = -OpenEnd;
		tfar = OpenEnd;
		for (int a = 0; a < 3; a++) begin
			lo = longint'($signed(b.bmin[a])) - longint'($signed(ray_org[a]));
			hi = longint'($signed(b.bmax[a])) - longint'($signed(ray_org[a]));
			d = longint'($signed(ray_dir[a]));
			if (d == 0) begin
				if (lo > 0 || hi < 0)
					return -1;
			end else begin
				t1 = (lo * 65536) / d;
				t2 = (hi * 65536) / d;
				if (t1 > t2) begin
					t = t1;
					t1 = t2;
					t2 = t;
				end
				if (t1 > tnear)
					tnear = t1;
				if (t2 < tfar)
					tfar = t2;
				if (tnear > tfar)
					return -1;
			end
		end
		t = (tnear >= 0) ? tnear : tfar;
		if (t < 0)
			return -1;
		return (t > DistSat) ? DistSat : t;
	endfunction

	function automatic void clear_scene();
		box_count = '0;
		best_dist = DistSat;
		best_pos = '0;
		best_ok = 1'b0;
	endfunction

	// Advances the scene for an accepted box and queues the pick it closes.
	function automatic void predict_pick(box_t b);
		longint t;
		pick_t p;
		if (b.sel) begin
			t = slab_distance(b);
			if (t >= 0 && t < best_dist) begin
				best_dist = t;
				best_pos = box_count;
				best_ok = 1'b1;
			end
		end
		if (!b.last) begin
			box_count = box_count + 1'b1;
			return;
		end
		if (best_ok && best_dist <= longint'(max_dist)) begin
			p.found = 1'b1;
			p.index = best_pos;
			p.distance = best_dist[30:0];
		end else begin
			p.found = 1'b0;
			p.index = '0;
			p.distance = '0;
		end
		pending_picks.push_back(p);
		clear_scene();
	endfunction

	// Waits until no pick is outstanding and the block has drained any open box.
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (pending_picks.size() != 0)
			@(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			RegOrgX: ray_org[0] = val;
			RegOrgY: ray_org[1] = val;
			RegOrgZ: ray_org[2] = val;
			RegDirX: ray_dir[0] = val;
			RegDirY: ray_dir[1] = val;
			RegDirZ: ray_dir[2] = val;
			RegMaxD: max_dist = val[30:0];
			default: ;
		endcase
	endtask

	task automatic set_ray(int ox, int oy, int oz, int dx, int dy, int dz, logic [31:0] md);
		wait_idle();
		write_reg(RegOrgX, ox);
		write_reg(RegOrgY, oy);
		write_reg(RegOrgZ, oz);
		write_reg(RegDirX, dx);
		write_reg(RegDirY, dy);
		write_reg(RegDirZ, dz);
		write_reg(RegMaxD, md);
	endtask

	// Sends one box, with random idle cycles ahead of it, and waits for its transfer.
	task automatic send_box(box_t b);
		logic took;
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {b.bmax[2], b.bmin[2], b.bmax[1], b.bmin[1], b.bmax[0], b.bmin[0]};
		s_axis_tuser <= b.sel;
		s_axis_tlast <= b.last;
		do begin
			@(negedge clk);
			took = s_axis_tready;
			@(posedge clk);
		end while (!took);
		predict_pick(b);
	endtask

	function automatic box_t make_box(int x0, int x1, int y0, int y1, int z0, int z1,
		logic sel, logic last);
		box_t b;
		b.bmin[0] = x0; b.bmax[0] = x1;
		b.bmin[1] = y0; b.bmax[1] = y1;
		b.bmin[2] = z0; b.bmax[2] = z1;
		b.sel = sel;
		b.last = last;
		return b;
	endfunction

	// Random box: mostly near the origin so hits are common, sometimes inverted or wild.
	function automatic box_t random_box(logic last);
		box_t b;
		int kind;
		int lo;
		kind = $urandom_range(99);
		for (int a = 0; a < 3; a++) begin
			if (kind < 8) begin
				b.bmin[a] = $urandom;
				b.bmax[a] = $urandom;
			end else begin
				lo = $signed($urandom_range(32'h0020_0000)) - 32'sh0010_0000;
				b.bmin[a] = lo;
				b.bmax[a] = lo + $signed($urandom_range(32'h0008_0000));
				if (kind < 14 && a == 0) begin
					b.bmin[a] = lo + 32'sh0008_0000;
					b.bmax[a] = lo;
				end
			end
		end
		b.sel = ($urandom_range(99) < 85);
		b.last = last;
		return b;
	endfunction

	function automatic int random_dir();
		int r;
		r = $urandom_range(99);
		if (r < 18)
			return 0;
		if (r < 24)
			return $urandom;
		return $signed($urandom_range(32'h0004_0000)) - 32'sh0002_0000;
	endfunction

	task automatic random_ray();
		int md;
		case ($urandom_range(5))
			0: md = 0;
			1: md = 32'h7FFF_FFFF;
			2: md = $urandom;
			default: md = $urandom_range(32'h0040_0000);
		endcase
		set_ray($signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000,
			$signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000,
			$signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000,
			random_dir(), random_dir(), random_dir(), md);
	endtask

	// Random scenes of mostly a few boxes; the final box always closes the scene.
	task automatic run_scenes(int n_boxes);
		int left;
		left = 0;
		for (int i = 0; i < n_boxes; i++) begin
			if (left == 0)
				left = $urandom_range(8);
			left--;
			send_box(random_box(left == 0 || i == n_boxes - 1));
		end
	endtask

	// Hand-picked boxes for the named corner cases.
	task automatic test_directed();
		// Reset ray: origin 0, direction +x, limit 8.0.
		send_box(make_box(32'h0001_0000, 32'h0002_0000, -32'h0001_0000, 32'h0001_0000,
			-32'h0001_0000, 32'h0001_0000, 1'b1, 1'b1));
		// Origin inside the box reports the exit distance.
		send_box(make_box(-32'h0001_0000, 32'h0003_0000, -32'h0001_0000, 32'h0001_0000,
			-32'h0001_0000, 32'h0001_0000, 1'b1, 1'b1));
		// Zero-direction axis miss, then an unselectable nearer box, then a tie.
		send_box(make_box(32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 32'h0002_0000,
			-32'h0001_0000, 32'h0001_0000, 1'b1, 1'b0));
		send_box(make_box(32'h0000_8000, 32'h0002_0000, -1, 1, -1, 1, 1'b0, 1'b0));
		send_box(make_box(32'h0003_0000, 32'h0004_0000, -1, 1, -1, 1, 1'b1, 1'b0));
		send_box(make_box(32'h0003_0000, 32'h0005_0000, -1, 1, -1, 1, 1'b1, 1'b1));
		// Inverted box on a zero axis, then inverted on the ray axis.
		send_box(make_box(32'h0001_0000, 32'h0002_0000, 1, -1, 0, 0, 1'b1, 1'b0));
		send_box(make_box(32'h0002_0000, 32'h0001_0000, 0, 0, 0, 0, 1'b1, 1'b1));
		// Beyond the limit, and a box behind the origin.
		send_box(make_box(32'h0009_0000, 32'h000A_0000, -1, 1, -1, 1, 1'b1, 1'b0));
		send_box(make_box(-32'h0004_0000, -32'h0002_0000, -1, 1, -1, 1, 1'b1, 1'b1));
		// Field extremes.
		send_box(make_box(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b1));
		send_box(make_box(32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 0, 1'b1, 1'b1));
		// Smallest direction step: distances saturate; also the ignored register index.
		set_ray(0, 0, 0, 1, 0, 0, 32'hFFFF_FFFF);
		write_reg(RegNone, 32'hDEAD_BEEF);
		send_box(make_box(32'h0010_0000, 32'h0020_0000, -1, 1, -1, 1, 1'b1, 1'b1));
		send_box(make_box(32'h8000_0000, 32'h7FFF_FFFF, -1, 1, -1, 1, 1'b1, 1'b1));
		// Extreme ray registers with a negative direction.
		set_ray(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
		send_box(make_box(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b1));
		// All directions zero with the origin inside: never picked.
		set_ray(0, 0, 0, 0, 0, 0, 32'h7FFF_FFFF);
		send_box(make_box(-1, 1, -1, 1, -1, 1, 1'b1, 1'b1));
		send_box(make_box(1, 2, -1, 1, -1, 1, 1'b1, 1'b1));
		// Zero limit: only a touching hit at distance zero is reported.
		set_ray(0, 0, 0, 32'h0001_0000, 32'h0000_8000, -32'h0002_0000, 0);
		send_box(make_box(0, 32'h0001_0000, -1, 32'h0001_0000, -32'h0001_0000, 1, 1'b1, 1'b1));
		send_box(make_box(32'h0001_0000, 32'h0002_0000, -32'h0004_0000, 32'h0004_0000,
			-32'h0004_0000, 32'h0004_0000, 1'b1, 1'b1));
	endtask

	// Long scene so the box position wraps past its 10-bit range.
	task automatic test_long_scene();
		set_ray(0, 0, 0, 32'h0001_0000, 0, 0, 32'h7FFF_FFFF);
		for (int i = 0; i < 1100; i++) begin
			if (i == 1030)
				send_box(make_box(32'h0000_4000, 32'h0001_0000, -1, 1, -1, 1, 1'b1, 1'b0));
			else
				send_box(random_box(i == 1099));
		end
	endtask

	// Random rays and scenes under each idling pattern.
	task automatic test_random(int idle_pct, int stall_pct, int n_boxes);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		for (int i = 0; i < n_boxes / 25; i++) begin
			random_ray();
			run_scenes(25);
		end
	endtask

	// The sender holds off until every pick is in before sending more.
	task automatic test_drain_pause();
		recv_stall_pct = 66;
		run_scenes(12);
		s_axis_tvalid <= 1'b0;
		while (pending_picks.size() != 0)
			@(posedge clk);
		run_scenes(12);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		s_axis_tlast = 1'b0;
		mismatches = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		ray_org[0] = '0; ray_org[1] = '0; ray_org[2] = '0;
		ray_dir[0] = 32'h0001_0000; ray_dir[1] = '0; ray_dir[2] = '0;
		max_dist = 31'h0008_0000;
		clear_scene();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(0, 0, 100);
		test_random(66, 0, 100);
		test_random(0, 66, 100);
		test_random(36, 36, 100);
		test_drain_pause();
		test_long_scene();
		test_random(0, 0, 25);

		wait_idle();
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule

### filelist.f
hdl/nrbp_pkg.sv
hdl/nrbp_div.sv
hdl/nearest_ray_box_pick_top.sv
tb/nearest_ray_box_pick_top_tb.sv
